// File: design/dht_pkg.sv
package dht_pkg;

  localparam int unsigned DepthDefault = 1024;
  localparam int unsigned KeyW  = 20;
  localparam int unsigned PayW  = 32;
  localparam int unsigned SizeW = 11;
  localparam int unsigned ModeW = 2;
  localparam int unsigned StatW = 3;
  localparam int unsigned SlotW = 10;

  localparam logic [ModeW-1:0] MODE_INSERT = 2'd0;
  localparam logic [ModeW-1:0] MODE_FIND   = 2'd1;
  localparam logic [ModeW-1:0] MODE_REMOVE = 2'd2;
  localparam logic [ModeW-1:0] MODE_NONE   = 2'd3;

  localparam logic [StatW-1:0] ST_INSERTED = 3'd0;
  localparam logic [StatW-1:0] ST_FULL     = 3'd1;
  localparam logic [StatW-1:0] ST_FOUND    = 3'd2;
  localparam logic [StatW-1:0] ST_MISSING  = 3'd3;
  localparam logic [StatW-1:0] ST_REMOVED  = 3'd4;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [KeyW-1:0]  key;
    logic [PayW-1:0]  payload;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [SlotW-1:0] slot;
    logic [PayW-1:0]  payload_out;
  } rsp_t;

endpackage

// File: design/dht_if.sv
interface dht_req_if import dht_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dht_rsp_if import dht_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/dht_mod.sv
// Serial restoring modulo: rem = a mod d, one quotient bit per cycle.
module dht_mod import dht_pkg::*; #(
  parameter int unsigned AW = KeyW + 1,
  parameter int unsigned DW = SizeW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [DW-1:0] d,
  output logic          done,
  output logic [DW-1:0] rem
);
  localparam int unsigned CntW = $clog2(AW + 1);

  logic [AW-1:0]   a_r, a_nxt;
  logic [DW:0]     r_r, r_nxt;
  logic [DW-1:0]   d_r, d_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [DW+1:0]   sh;
  logic [DW+1:0]   dif;

  always_comb begin
    a_nxt = a_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    sh  = {r_r, a_r[AW-1]};
    dif = sh - {2'b00, d_r};
    if (start) begin
      a_nxt = a; d_nxt = d; r_nxt = '0; cnt_nxt = CntW'(AW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      a_nxt = {a_r[AW-2:0], 1'b0};
      r_nxt = dif[DW+1] ? sh[DW:0] : dif[DW:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; r_r <= r_nxt; d_r <= d_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign rem  = r_r[DW-1:0];

endmodule

// File: design/double_hash_table.sv
// Double-hashed open-address table. Requests arrive on in_ (mode, key,
// payload); each gives one item on out_ (status, slot, payload_out).
// cfg_we/cfg_wdata set table_size; the user must write them only while
// the block is idle, as the block itself does not enforce it. Per request:
// two serial modulo passes for h1 and h2, then the probes; each probe is
// a memory read state followed by a check state. An unused mode answers
// ST_MISSING after the h2 pass without probing. One request is in flight
// at a time: the next one is taken the cycle after the result has left.
// Reset sets table_size to 1024 and starts a sweep that clears the used
// bit of all DEPTH slots (1024 by default), one slot per cycle; in_ready
// stays low until the sweep ends. A result waits in the output register
// while out_ready is low; no new request is taken meanwhile.
module double_hash_table import dht_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  dht_req_if.sink           in_ch,
  dht_rsp_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [SizeW-1:0]  cfg_wdata
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned NW = AW + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_H1 = 7'b0000010, S_H2 = 7'b0000100,
    S_RD   = 7'b0001000, S_CHK = 7'b0010000, S_OUT = 7'b0100000,
    S_CLR  = 7'b1000000
  } state_t;

  state_t           st_r, st_nxt;
  logic [SizeW-1:0] size_r;
  logic [NW-1:0]    n_r;
  req_t             req_r;
  logic [NW-1:0]    idx_r, idx_nxt, h2_r, h2_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  rsp_t             rsp_r, rsp_nxt;
  logic [AW-1:0]    sweep_r;
  logic             used_mem [DEPTH];
  logic [KeyW-1:0]  key_mem [DEPTH];
  logic [PayW-1:0]  pay_mem [DEPTH];
  logic [KeyW-1:0]  key_q;
  logic [PayW-1:0]  pay_q;
  logic             used_q;
  logic             wr, clr;
  logic             used_we, used_wd;
  logic [AW-1:0]    used_wa;
  logic             md_start, md_done;
  logic [KeyW:0]    md_a;
  logic [SizeW-1:0] md_rem;
  logic [NW-1:0]    n_eff, rem_n, step;

  // effective size, clamped to 1..DEPTH
  always_comb begin
    if (size_r == '0) n_eff = NW'(1);
    else if ({{(32-SizeW){1'b0}}, size_r} > DEPTH) n_eff = NW'(DEPTH);
    else n_eff = NW'(size_r);
  end

  assign rem_n = NW'(md_rem);
  assign md_a  = (st_r == S_IDLE) ? {1'b0, in_ch.data.key}
                                  : {1'b0, req_r.key} + 1'b1;
  assign md_start = (in_ch.valid && in_ch.ready) || (st_r == S_H1 && md_done);

  dht_mod #(.AW(KeyW + 1), .DW(SizeW)) u_mod (
    .clk, .rst_n, .start(md_start), .a(md_a),
    .d((st_r == S_IDLE) ? SizeW'(n_eff) : SizeW'(n_r)),
    .done(md_done), .rem(md_rem)
  );

  // used-bit write port: sweep after reset, else insert or remove
  assign used_we = (st_r == S_CLR) || wr || clr;
  assign used_wa = (st_r == S_CLR) ? sweep_r : idx_r[AW-1:0];
  assign used_wd = wr;

  // slot memories, read at idx_r
  always_ff @(posedge clk) begin
    key_q <= key_mem[idx_r[AW-1:0]];
    pay_q <= pay_mem[idx_r[AW-1:0]];
    used_q <= used_mem[idx_r[AW-1:0]];
    if (wr) begin
      key_mem[idx_r[AW-1:0]] <= req_r.key;
      pay_mem[idx_r[AW-1:0]] <= req_r.payload;
    end
    if (used_we) used_mem[used_wa] <= used_wd;
  end

  assign step = idx_r + h2_r;

  // probe sequencer
  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; h2_nxt = h2_r; cnt_nxt = cnt_r;
    rsp_nxt = rsp_r; wr = 1'b0; clr = 1'b0;
    case (st_r)
      S_CLR: if (sweep_r == AW'(DEPTH - 1)) st_nxt = S_IDLE;
      S_IDLE: if (in_ch.valid) st_nxt = S_H1;
      S_H1: if (md_done) begin
        idx_nxt = (rem_n == '0) ? n_r - 1'b1 : rem_n - 1'b1;
        st_nxt = S_H2;
      end
      S_H2: if (md_done) begin
        h2_nxt = rem_n; cnt_nxt = '0;
        if (req_r.mode == MODE_NONE) begin
          rsp_nxt = '{ST_MISSING, '0, '0}; st_nxt = S_OUT;
        end else st_nxt = S_RD;
      end
      S_RD: st_nxt = S_CHK;
      S_CHK: begin
        if (req_r.mode == MODE_INSERT && !used_q) begin
          wr = 1'b1; rsp_nxt = '{ST_INSERTED, SlotW'(idx_r), '0}; st_nxt = S_OUT;
        end else if (req_r.mode != MODE_INSERT && used_q && key_q == req_r.key) begin
          clr = (req_r.mode == MODE_REMOVE);
          rsp_nxt = '{(clr ? ST_REMOVED : ST_FOUND), SlotW'(idx_r), pay_q};
          st_nxt = S_OUT;
        end else if (cnt_r == n_r - 1'b1) begin
          rsp_nxt = '{((req_r.mode == MODE_INSERT) ? ST_FULL : ST_MISSING), '0, '0};
          st_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          idx_nxt = (step >= n_r) ? step - n_r : step;
          st_nxt = S_RD;
        end
      end
      S_OUT: if (out_ch.ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; h2_r <= h2_nxt; cnt_r <= cnt_nxt; rsp_r <= rsp_nxt;
    if (st_r == S_IDLE) begin
      req_r <= in_ch.data; n_r <= n_eff;
    end
    if (!rst_n) begin
      st_r <= S_CLR; size_r <= SizeW'(1024); sweep_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) size_r <= cfg_wdata;
      if (st_r == S_CLR) sweep_r <= sweep_r + 1'b1;
    end
  end

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.data  = rsp_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CHK) |-> (idx_r < n_r)) else $error("probe index out of range");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr && clr)) else $error("insert and remove together");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(rsp_r))
    else $error("result dropped");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CHK) |-> (cnt_r < n_r)) else $error("probe count overrun");

endmodule

// File: tb/sv/tb_double_hash_table.sv
module tb_double_hash_table;
  import dht_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [SizeW-1:0] cfg_wdata;

  dht_req_if req_ch ();
  dht_rsp_if rsp_ch ();

  double_hash_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch.sink),
    .out_ch    (rsp_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the table contents and size
  logic                used_q [DepthDefault];
  logic [KeyW-1:0]     key_q  [DepthDefault];
  logic [PayW-1:0]     pay_q  [DepthDefault];
  logic [SizeW-1:0]    size_q;

  req_t pending_items [$];
  rsp_t expected_rsps [$];
  int   n_errors;
  int   n_checked;
  int   n_sent;
  int   gap_left;
  int   burst_left;
  logic [KeyW-1:0] live_keys [$];

  // Work out the response of one request and update the shadow table
  function automatic rsp_t lookup_table(req_t r);
    rsp_t o;
    int unsigned n, h1, h2, idx;
    o = '0;
    n = size_q;
    if (n == 0) n = 1;
    if (n > DepthDefault) n = DepthDefault;
    h1 = (r.key % n == 0) ? n - 1 : r.key % n - 1;
    h2 = (r.key + 1) % n;
    idx = h1;
    o.status = (r.mode == MODE_INSERT) ? ST_FULL : ST_MISSING;
    if (r.mode != MODE_INSERT && r.mode != MODE_FIND && r.mode != MODE_REMOVE)
      return o;
    for (int i = 0; i < n; i++) begin
      if (r.mode == MODE_INSERT) begin
        if (!used_q[idx]) begin
          used_q[idx] = 1'b1;
          key_q[idx] = r.key;
          pay_q[idx] = r.payload;
          o.status = ST_INSERTED;
          o.slot = idx[SlotW-1:0];
          return o;
        end
      end else if (used_q[idx] && key_q[idx] == r.key) begin
        o.slot = idx[SlotW-1:0];
        o.payload_out = pay_q[idx];
        if (r.mode == MODE_REMOVE) begin
          used_q[idx] = 1'b0;
          o.status = ST_REMOVED;
        end else begin
          o.status = ST_FOUND;
        end
        return o;
      end
      idx += h2;
      if (idx >= n) idx -= n;
    end
    return o;
  endfunction

  function automatic req_t make_req(logic [ModeW-1:0] m, logic [KeyW-1:0] k,
                                    logic [PayW-1:0] p);
    req_t r;
    r.mode = m;
    r.key = k;
    r.payload = p;
    return r;
  endfunction

  // Pick a key: mostly from the small recent set so finds and removes hit
  function automatic logic [KeyW-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6 && live_keys.size() > 0)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    if (sel == 6) return KeyW'($urandom);
    if (sel == 7) return KeyW'($urandom_range(0, 40));
    return KeyW'($urandom_range(1, 999999));
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(lookup_table(req_ch.data));
        n_sent <= n_sent + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          req_ch.valid <= 1'b1;
          req_ch.data <= pending_items.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall pattern on ready, compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_checked <= n_checked + 1;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp_ch.data);
          n_errors <= n_errors + 1;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (e !== rsp_ch.data) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, rsp_ch.data);
            n_errors <= n_errors + 1;
          end
        end
      end
      case ((n_checked / 64) % 3)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk);
    // then let the block settle
    repeat (2 * DepthDefault + 100) @(posedge clk);
  endtask

  task automatic write_size(logic [SizeW-1:0] s);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_q = s;
  endtask

  // One phase of random traffic at the current size
  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      logic [KeyW-1:0] k;
      int unsigned m;
      k = pick_key();
      m = $urandom_range(0, 19);
      if (m < 9) begin
        pending_items.push_back(make_req(MODE_INSERT, k, $urandom));
        live_keys.push_back(k);
        if (live_keys.size() > 24) void'(live_keys.pop_front());
      end else if (m < 14) pending_items.push_back(make_req(MODE_FIND, k, $urandom));
      else if (m < 19) pending_items.push_back(make_req(MODE_REMOVE, k, $urandom));
      else pending_items.push_back(make_req(MODE_NONE, k, $urandom));
    end
  endtask

  initial begin
    logic [SizeW-1:0] sizes [8];
    sizes = '{11'd1, 11'd2, 11'd7, 11'd16, 11'd0, 11'd1024, 11'd2047, 11'd61};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    n_errors = 0;
    n_checked = 0;
    n_sent = 0;
    size_q = 11'd1024;
    foreach (used_q[i]) begin
      used_q[i] = 1'b0;
      key_q[i] = '0;
      pay_q[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every mode, key zero, zero step, duplicates
    pending_items.push_back(make_req(MODE_FIND, 20'd5, '0));
    pending_items.push_back(make_req(MODE_INSERT, 20'd1, 32'hFFFF_FFFF));
    pending_items.push_back(make_req(MODE_INSERT, 20'd0, 32'h0));
    pending_items.push_back(make_req(MODE_INSERT, 20'hFFFFF, 32'hA5A5_5A5A));
    pending_items.push_back(make_req(MODE_INSERT, 20'd999999, 32'h5A5A_A5A5));
    pending_items.push_back(make_req(MODE_INSERT, 20'd1023, 32'h1234_5678));
    pending_items.push_back(make_req(MODE_INSERT, 20'd1, 32'h0000_0001));
    pending_items.push_back(make_req(MODE_FIND, 20'd1, '1));
    pending_items.push_back(make_req(MODE_FIND, 20'd0, '0));
    pending_items.push_back(make_req(MODE_FIND, 20'hFFFFF, '0));
    pending_items.push_back(make_req(MODE_REMOVE, 20'd1, '0));
    pending_items.push_back(make_req(MODE_FIND, 20'd1, '0));
    pending_items.push_back(make_req(MODE_REMOVE, 20'd1023, '0));
    pending_items.push_back(make_req(MODE_REMOVE, 20'd1023, '0));
    pending_items.push_back(make_req(MODE_NONE, 20'd999999, '1));
    wait_drained();

    // Small table: shrink, fill up, zero step
    write_size(11'd4);
    pending_items.push_back(make_req(MODE_INSERT, 20'd3, 32'h11));
    for (int i = 0; i < 5; i++)
      pending_items.push_back(make_req(MODE_INSERT, 20'd5 + i, $urandom));
    pending_items.push_back(make_req(MODE_FIND, 20'd3, '0));
    wait_drained();

    foreach (sizes[s]) begin
      write_size(sizes[s]);
      random_phase(220);
      wait_drained();
    end

    $display("Covered %0d requests over sizes 0 to 2047, all modes, full tables", n_sent);
    $display("and %0d results checked with random handshake stalls", n_checked);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: double_hash_table.f
design/dht_pkg.sv
design/dht_if.sv
design/dht_mod.sv
design/double_hash_table.sv
tb/sv/tb_double_hash_table.sv
